>>> hw/rtl/accm_pkg.sv
`default_nettype none

package accm_pkg;

	// Default sizes of the data memory and the accumulator
	localparam int DATA_DEPTH_DEF = 256;
	localparam int WORD_BITS_DEF  = 32;

	// Instruction codes
	localparam logic [7:0] OP_ADD = 8'h01;
	localparam logic [7:0] OP_SUB = 8'h02;
	localparam logic [7:0] OP_MUL = 8'h03;
	localparam logic [7:0] OP_DIV = 8'h04;
	localparam logic [7:0] OP_LDA = 8'h05;
	localparam logic [7:0] OP_LDK = 8'h06;
	localparam logic [7:0] OP_STA = 8'h07;
	localparam logic [7:0] OP_INP = 8'h08;
	localparam logic [7:0] OP_OUT = 8'h09;
	localparam logic [7:0] OP_HLT = 8'h0A;
	localparam logic [7:0] OP_JMP = 8'h0B;
	localparam logic [7:0] OP_JEZ = 8'h0C;
	localparam logic [7:0] OP_JNE = 8'h0D;
	localparam logic [7:0] OP_JLZ = 8'h0E;
	localparam logic [7:0] OP_JLE = 8'h0F;
	localparam logic [7:0] OP_JGZ = 8'h10;
	localparam logic [7:0] OP_JGE = 8'h11;

	// Status reported with each result word
	typedef enum logic [1:0] {
		ST_RUN       = 2'd0,
		ST_HALT      = 2'd1,
		ST_UNWRITTEN = 2'd2,
		ST_DIVZERO   = 2'd3
	} status_t;

	// Execute sequencer states
	typedef enum logic [1:0] {
		EX_IDLE,
		EX_EXEC,
		EX_BUSY,
		EX_FIN
	} ex_state_t;

	// Multiply/divide unit states
	typedef enum logic [1:0] {
		MD_IDLE,
		MD_RUN,
		MD_FIX
	} md_state_t;

	// Command from the sequencer to the multiply/divide unit
	typedef struct packed {
		logic start;
		logic is_div;
	} md_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/accm_if.sv
`default_nettype none

// Instruction channel
interface accm_in_if;
	logic               valid;
	logic               ready;
	logic [7:0]         opcode;
	logic [7:0]         operand;
	logic signed [31:0] in_value;

	modport source (output valid, output opcode, output operand, output in_value,
		input ready);
	modport sink (input valid, input opcode, input operand, input in_value,
		output ready);
endinterface

// Result channel
interface accm_out_if;
	logic               valid;
	logic               ready;
	logic [7:0]         next_address;
	logic               out_valid;
	logic signed [31:0] out_value;
	logic signed [31:0] acc_value;
	logic [1:0]         status;

	modport source (output valid, output next_address, output out_valid,
		output out_value, output acc_value, output status, input ready);
	modport sink (input valid, input next_address, input out_valid,
		input out_value, input acc_value, input status, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/accm_muldiv.sv
`default_nettype none

module accm_muldiv
	import accm_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire md_ctrl_t             ctrl,
	input  wire logic [WORD_BITS-1:0] a,
	input  wire logic [WORD_BITS-1:0] b,
	output logic                      done,
	output logic [WORD_BITS-1:0]      result
);

	localparam int CNT_BITS = $clog2(WORD_BITS);

	md_state_t             state_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  div_q;
	logic                  neg_q;
	logic [WORD_BITS-1:0]  x_q;
	logic [WORD_BITS-1:0]  y_q;
	logic [WORD_BITS-1:0]  r_q;
	logic                  done_q;
	logic [WORD_BITS-1:0]  result_q;

	logic [WORD_BITS-1:0]  a_mag;
	logic [WORD_BITS-1:0]  b_mag;
	logic [WORD_BITS:0]    trial;
	logic [WORD_BITS:0]    add_a;
	logic [WORD_BITS-1:0]  add_b;
	logic [WORD_BITS+1:0]  add_out;
	logic                  ge;

	// Magnitudes of the signed operands for division
	assign a_mag = a[WORD_BITS-1] ? (~a + 1'b1) : a;
	assign b_mag = b[WORD_BITS-1] ? (~b + 1'b1) : b;

	// Shared adder: add for multiply, trial subtract for divide
	assign trial = {r_q, x_q[WORD_BITS-1]};
	assign add_a = div_q ? trial : {1'b0, r_q};
	assign add_b = div_q ? y_q : x_q;
	always_comb begin
		if (div_q) begin
			add_out = {1'b0, add_a} + ~{2'b00, add_b} + 1'b1;
		end else begin
			add_out = {1'b0, add_a} + {2'b00, add_b};
		end
	end
	assign ge = ~add_out[WORD_BITS+1];

	// Sequence one step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MD_IDLE: begin
					if (ctrl.start) begin
						state_q <= MD_RUN;
						cnt_q   <= CNT_BITS'(WORD_BITS - 1);
					end
				end
				MD_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= MD_FIX;
					end
				end
				MD_FIX: begin
					state_q <= MD_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= MD_IDLE;
			endcase
		end
	end

	// Operand and partial result registers
	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (ctrl.start) begin
					div_q <= ctrl.is_div;
					neg_q <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
					x_q   <= ctrl.is_div ? a_mag : a;
					y_q   <= ctrl.is_div ? b_mag : b;
					r_q   <= '0;
				end
			end
			MD_RUN: begin
				if (div_q) begin
					r_q <= ge ? add_out[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
					x_q <= {x_q[WORD_BITS-2:0], ge};
				end else begin
					if (y_q[0]) begin
						r_q <= add_out[WORD_BITS-1:0];
					end
					x_q <= {x_q[WORD_BITS-2:0], 1'b0};
					y_q <= {1'b0, y_q[WORD_BITS-1:1]};
				end
			end
			MD_FIX: begin
				if (div_q) begin
					result_q <= neg_q ? (~x_q + 1'b1) : x_q;
				end else begin
					result_q <= r_q;
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

>>> hw/rtl/accm_dmem.sv
`default_nettype none

module accm_dmem
	import accm_pkg::*;
#(
	parameter int DATA_DEPTH = DATA_DEPTH_DEF,
	parameter int WORD_BITS  = WORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 rd_en,
	input  wire logic [7:0]           rd_addr,
	input  wire logic                 wr_en,
	input  wire logic [7:0]           wr_addr,
	input  wire logic [WORD_BITS-1:0] wr_data,
	output logic [WORD_BITS-1:0]      rd_data,
	output logic                      rd_ok
);

	localparam int ADDR_BITS = $clog2(DATA_DEPTH);

	logic [WORD_BITS-1:0]  mem [DATA_DEPTH];
	logic [DATA_DEPTH-1:0] written_q;
	logic [WORD_BITS-1:0]  rd_data_q;
	logic                  rd_ok_q;
	logic                  rd_in_range;
	logic                  wr_in_range;

	// Addresses past the end of memory read as unwritten and drop writes
	assign rd_in_range = {1'b0, rd_addr} < 9'(DATA_DEPTH);
	assign wr_in_range = {1'b0, wr_addr} < 9'(DATA_DEPTH);

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en && wr_in_range) begin
			mem[wr_addr[ADDR_BITS-1:0]] <= wr_data;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr[ADDR_BITS-1:0]];
		end
	end

	// Written bits, one per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_ok_q   <= 1'b0;
		end else begin
			if (wr_en && wr_in_range) begin
				written_q[wr_addr[ADDR_BITS-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				rd_ok_q <= rd_in_range && written_q[rd_addr[ADDR_BITS-1:0]];
			end
		end
	end

	assign rd_data = rd_data_q;
	assign rd_ok   = rd_ok_q;

endmodule

`default_nettype wire

>>> hw/rtl/accumulator_machine_execute.sv
// Execute unit of a one-accumulator machine.
// in_ch carries one fetched instruction word (opcode, operand, in_value);
// out_ch returns one result word per instruction: next fetch address,
// emitted value with its flag, accumulator after the step and status.
// in_ch.ready is high only while the unit is idle; one instruction is worked
// on at a time. The operand word is read from data memory at acceptance.
// Each instruction passes through the memory read at acceptance, the execute
// step and the result register; MUL and DIV also pass through the shared
// shift-add / restoring divide unit, which does one bit per cycle. A new
// instruction is accepted only after the last one has loaded the result
// register.
// A result that the receiver has not taken yet sits in the output register;
// the next instruction is still accepted and worked on, and it waits for
// that register to drain before finishing.
// Reset clears the accumulator, the halted flag and all written bits of the
// data memory, and sets the instruction address to one. After HLT or an
// error every further instruction reports halted with the state unchanged.
`default_nettype none

module accumulator_machine_execute
	import accm_pkg::*;
#(
	parameter int DATA_DEPTH = DATA_DEPTH_DEF,
	parameter int WORD_BITS  = WORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	accm_in_if.sink    in_ch,
	accm_out_if.source out_ch
);

	ex_state_t            state_q;
	ex_state_t            state_d;
	logic [7:0]           op_q;
	logic [7:0]           arg_q;
	logic [31:0]          inv_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [7:0]           addr_q;
	logic                 halted_q;
	status_t              st_q;
	logic                 emit_q;
	logic [WORD_BITS-1:0] emit_val_q;

	logic                 ovalid_q;
	logic [7:0]           o_next_q;
	logic                 o_emit_q;
	logic [31:0]          o_value_q;
	logic [31:0]          o_acc_q;
	logic [1:0]           o_status_q;

	logic                 accept;
	logic                 mem_wr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [WORD_BITS-1:0] m;
	logic                 m_ok;
	md_ctrl_t             md_ctrl;
	logic                 md_done;
	logic [WORD_BITS-1:0] md_result;

	logic                 reads;
	logic                 acc_neg;
	logic                 acc_zero;
	status_t              st_d;
	logic                 jump_d;
	logic                 load_acc;
	logic [WORD_BITS-1:0] acc_d;
	logic                 fin_load;
	logic [WORD_BITS+31:0] inv_ext;
	logic [WORD_BITS+31:0] acc_ext;
	logic [WORD_BITS+31:0] emit_ext;

	assign accept = in_ch.valid && in_ch.ready;

	// Data memory with written bits
	accm_dmem #(
		.DATA_DEPTH (DATA_DEPTH),
		.WORD_BITS  (WORD_BITS)
	) u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_ch.operand),
		.wr_en   (mem_wr),
		.wr_addr (arg_q),
		.wr_data (mem_wdata),
		.rd_data (m),
		.rd_ok   (m_ok)
	);

	// Shared multiply/divide unit
	accm_muldiv #(
		.WORD_BITS (WORD_BITS)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (md_ctrl),
		.a      (acc_q),
		.b      (m),
		.done   (md_done),
		.result (md_result)
	);

	// Resize between the 32-bit ports and the accumulator word
	assign inv_ext  = {{WORD_BITS{inv_q[31]}}, inv_q};
	assign acc_ext  = {{32{acc_q[WORD_BITS-1]}}, acc_q};
	assign emit_ext = {{32{emit_val_q[WORD_BITS-1]}}, emit_val_q};

	assign reads    = (op_q >= OP_ADD && op_q <= OP_LDA) || op_q == OP_OUT;
	assign acc_neg  = acc_q[WORD_BITS-1];
	assign acc_zero = acc_q == '0;

	// Decode the instruction against the current state
	always_comb begin
		st_d     = ST_RUN;
		jump_d   = 1'b0;
		load_acc = 1'b0;
		acc_d    = acc_q;
		if (halted_q) begin
			st_d = ST_HALT;
		end else if (reads && !m_ok) begin
			st_d = ST_UNWRITTEN;
		end else if (op_q == OP_DIV && m == '0) begin
			st_d = ST_DIVZERO;
		end else begin
			case (op_q)
				OP_ADD: begin
					load_acc = 1'b1;
					acc_d    = acc_q + m;
				end
				OP_SUB: begin
					load_acc = 1'b1;
					acc_d    = acc_q - m;
				end
				OP_LDA: begin
					load_acc = 1'b1;
					acc_d    = m;
				end
				OP_LDK: begin
					load_acc = 1'b1;
					acc_d    = WORD_BITS'({{WORD_BITS{1'b0}}, arg_q});
				end
				OP_HLT: st_d = ST_HALT;
				OP_JMP: jump_d = 1'b1;
				OP_JEZ: jump_d = acc_zero;
				OP_JNE: jump_d = !acc_zero;
				OP_JLZ: jump_d = acc_neg;
				OP_JLE: jump_d = acc_neg || acc_zero;
				OP_JGZ: jump_d = !acc_neg && !acc_zero;
				OP_JGE: jump_d = !acc_neg;
				default: ;
			endcase
		end
	end

	// Sequencer: next state and control
	always_comb begin
		state_d        = state_q;
		in_ch.ready    = 1'b0;
		md_ctrl.start  = 1'b0;
		md_ctrl.is_div = op_q == OP_DIV;
		mem_wr         = 1'b0;
		mem_wdata      = (op_q == OP_INP) ? inv_ext[WORD_BITS-1:0] : acc_q;
		fin_load       = 1'b0;
		case (state_q)
			EX_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = EX_EXEC;
				end
			end
			EX_EXEC: begin
				mem_wr = st_d == ST_RUN && (op_q == OP_STA || op_q == OP_INP);
				if (st_d == ST_RUN && (op_q == OP_MUL || op_q == OP_DIV)) begin
					md_ctrl.start = 1'b1;
					state_d       = EX_BUSY;
				end else begin
					state_d = EX_FIN;
				end
			end
			EX_BUSY: begin
				if (md_done) begin
					state_d = EX_FIN;
				end
			end
			EX_FIN: begin
				if (!ovalid_q || out_ch.ready) begin
					fin_load = 1'b1;
					state_d  = EX_IDLE;
				end
			end
			default: state_d = EX_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= EX_IDLE;
			acc_q    <= '0;
			addr_q   <= 8'd1;
			halted_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == EX_EXEC) begin
				if (load_acc) begin
					acc_q <= acc_d;
				end
				if (st_d != ST_RUN) begin
					halted_q <= 1'b1;
				end else if (jump_d) begin
					addr_q <= arg_q;
				end else begin
					addr_q <= addr_q + 8'd1;
				end
			end
			if (state_q == EX_BUSY && md_done) begin
				acc_q <= md_result;
			end
			if (fin_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Hold the instruction and the step's outcome
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_ch.opcode;
			arg_q <= in_ch.operand;
			inv_q <= in_ch.in_value;
		end
		if (state_q == EX_EXEC) begin
			st_q       <= st_d;
			emit_q     <= st_d == ST_RUN && op_q == OP_OUT;
			emit_val_q <= (st_d == ST_RUN && op_q == OP_OUT) ? m : '0;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (fin_load) begin
			o_next_q   <= addr_q;
			o_emit_q   <= emit_q;
			o_value_q  <= emit_ext[31:0];
			o_acc_q    <= acc_ext[31:0];
			o_status_q <= st_q;
		end
	end

	assign out_ch.valid        = ovalid_q;
	assign out_ch.next_address = o_next_q;
	assign out_ch.out_valid    = o_emit_q;
	assign out_ch.out_value    = o_value_q;
	assign out_ch.acc_value    = o_acc_q;
	assign out_ch.status       = o_status_q;

endmodule

`default_nettype wire

>>> bench/accumulator_machine_execute_tb.sv
`timescale 1ns / 100ps

module accumulator_machine_execute_tb;
	import accm_pkg::*;

	localparam int NUM_RANDOM  = 1500;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 60;

	// One result word as seen on the result channel
	typedef struct {
		logic [7:0]  next_address;
		logic        out_valid;
		logic [31:0] out_value;
		logic [31:0] acc_value;
		logic [1:0]  status;
	} step_result_t;

	// Machine state mirror: predicts the result word of every accepted instruction
	class step_predictor;
		logic signed [31:0] acc;
		logic [7:0]         pc;
		logic [31:0]        mem [256];
		bit                 written [256];
		bit                 halted;
		step_result_t       pending_steps [$];
		int                 errors;

		function new();
			acc = '0;
			pc = 8'd1;
			halted = 1'b0;
			errors = 0;
			foreach (written[i]) begin
				written[i] = 1'b0;
				mem[i] = '0;
			end
		endfunction

		// Execute one instruction and queue the word it must produce
		function void note_instr(logic [7:0] op, logic [7:0] arg, logic signed [31:0] inval);
			step_result_t r;
			logic signed [31:0] m;
			logic [7:0] nxt;
			logic take, reads, neg, zero;
			longint q;
			r.out_valid = 1'b0;
			r.out_value = '0;
			r.status = ST_RUN;
			m = '0;
			take = 1'b0;
			nxt = pc + 8'd1;
			neg = acc[31];
			zero = (acc == 0);
			if (halted) begin
				r.status = ST_HALT;
			end else begin
				reads = (op >= OP_ADD && op <= OP_LDA) || op == OP_OUT;
				if (reads && !written[arg]) begin
					r.status = ST_UNWRITTEN;
				end else begin
					if (reads)
						m = mem[arg];
					if (op == OP_DIV && m == 0) begin
						r.status = ST_DIVZERO;
					end else begin
						case (op)
							OP_ADD: acc = acc + m;
							OP_SUB: acc = acc - m;
							OP_MUL: acc = acc * m;
							OP_DIV: begin
								// 64-bit quotient so that min / -1 wraps cleanly
								q = longint'(acc) / longint'(m);
								acc = q[31:0];
							end
							OP_LDA: acc = m;
							OP_LDK: acc = {24'd0, arg};
							OP_STA: begin
								mem[arg] = acc;
								written[arg] = 1'b1;
							end
							OP_INP: begin
								mem[arg] = inval;
								written[arg] = 1'b1;
							end
							OP_OUT: begin
								r.out_valid = 1'b1;
								r.out_value = m;
							end
							OP_HLT: r.status = ST_HALT;
							OP_JMP: take = 1'b1;
							OP_JEZ: take = zero;
							OP_JNE: take = !zero;
							OP_JLZ: take = neg;
							OP_JLE: take = neg || zero;
							OP_JGZ: take = !neg && !zero;
							OP_JGE: take = !neg;
							default: ;
						endcase
					end
				end
				if (r.status != ST_RUN)
					halted = 1'b1;
			end
			if (r.status != ST_RUN)
				nxt = pc;
			else if (take)
				nxt = arg;
			pc = nxt;
			r.next_address = pc;
			r.acc_value = acc;
			pending_steps.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		// Match a result word against the oldest prediction
		function void check_result(step_result_t got);
			step_result_t want;
			if (pending_steps.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual addr %h acc %h",
					$time, got.next_address, got.acc_value);
				errors++;
				return;
			end
			want = pending_steps.pop_front();
			compare_field("next_address", want.next_address, got.next_address);
			compare_field("out_valid", want.out_valid, got.out_valid);
			compare_field("out_value", want.out_value, got.out_value);
			compare_field("acc_value", want.acc_value, got.acc_value);
			compare_field("status", want.status, got.status);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	int   quiet_cycles;

	step_predictor model;
	logic [7:0]    stored_addrs [$];
	bit            stored [256];

	accm_in_if  in_ch ();
	accm_out_if out_ch ();

	accumulator_machine_execute i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Drive result ready with random back-pressure
	initial out_ch.ready = 1'b0;
	always @(negedge clk) begin
		out_ch.ready <= steady || ($urandom_range(99) >= 11);
	end

	// Check each result word taken by the receiver
	always @(posedge clk) begin
		step_result_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.next_address = out_ch.next_address;
			got.out_valid = out_ch.out_valid;
			got.out_value = out_ch.out_value;
			got.acc_value = out_ch.acc_value;
			got.status = out_ch.status;
			model.check_result(got);
		end
	end

	// Abort when no word moves on either channel for too long
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Present one instruction word and hold it until accepted
	task automatic send_instr(input logic [7:0] op, input logic [7:0] arg,
		input logic [31:0] inval);
		@(negedge clk);
		if (!steady && $urandom_range(99) < 11) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		in_ch.opcode = op;
		in_ch.operand = arg;
		in_ch.in_value = inval;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		model.note_instr(op, arg, inval);
	endtask

	// Track written words so that reads only hit them, then send
	task automatic run_instr(input logic [7:0] op, input logic [7:0] arg,
		input logic [31:0] inval);
		if ((op == OP_STA || op == OP_INP) && !stored[arg]) begin
			stored[arg] = 1'b1;
			stored_addrs.push_back(arg);
		end
		send_instr(op, arg, inval);
	endtask

	// Drop valid and hold off until every result has come back
	task automatic drain_results();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (model.pending_steps.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] pick_stored();
		return stored_addrs[$urandom_range(stored_addrs.size() - 1)];
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'($urandom_range(16));
			default: return $urandom;
		endcase
	endfunction

	// Build one well-formed random instruction
	task automatic random_instr(output logic [7:0] op, output logic [7:0] arg,
		output logic [31:0] inval);
		int pick;
		int tries;
		pick = $urandom_range(99);
		arg = 8'($urandom_range(255));
		inval = $urandom;
		if (pick < 8) begin
			op = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255, OP_JGE + 1));
		end else if (pick < 20) begin
			op = OP_INP;
			inval = pick_value();
		end else if (pick < 28) begin
			op = OP_STA;
		end else if (pick < 36) begin
			op = OP_LDK;
		end else if (pick < 80) begin
			arg = pick_stored();
			if (pick < 48) op = OP_LDA;
			else if (pick < 56) op = OP_ADD;
			else if (pick < 62) op = OP_SUB;
			else if (pick < 68) op = OP_MUL;
			else if (pick < 74) op = OP_DIV;
			else op = OP_OUT;
			// keep the divisor nonzero, a zero one would halt the machine
			if (op == OP_DIV) begin
				tries = 0;
				while (model.mem[arg] == 0 && tries < 8) begin
					arg = pick_stored();
					tries++;
				end
				if (model.mem[arg] == 0)
					op = OP_LDA;
			end
		end else if (pick < 85) begin
			op = OP_JMP;
		end else begin
			op = 8'($urandom_range(OP_JGE, OP_JEZ));
		end
	endtask

	initial begin
		logic [7:0]  op;
		logic [7:0]  arg;
		logic [31:0] inval;
		model = new();
		foreach (stored[i]) stored[i] = 1'b0;
		steady = 1'b0;
		quiet_cycles = 0;
		in_ch.valid = 1'b0;
		in_ch.opcode = '0;
		in_ch.operand = '0;
		in_ch.in_value = '0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, every opcode but HLT, min / -1, wrap, no-ops
		run_instr(OP_INP, 8'h00, 32'h7FFF_FFFF);
		run_instr(OP_INP, 8'hFF, 32'h8000_0000);
		run_instr(OP_INP, 8'h01, 32'hFFFF_FFFF);
		run_instr(OP_INP, 8'h02, 32'h0000_0000);
		run_instr(OP_LDA, 8'hFF, $urandom);
		run_instr(OP_JLZ, 8'h40, $urandom);
		run_instr(OP_DIV, 8'h01, $urandom);
		run_instr(OP_JLE, 8'hAA, $urandom);
		run_instr(OP_SUB, 8'h01, $urandom);
		run_instr(OP_LDA, 8'h00, $urandom);
		run_instr(OP_ADD, 8'h00, $urandom);
		run_instr(OP_MUL, 8'h00, $urandom);
		run_instr(OP_LDK, 8'hFF, $urandom);
		run_instr(OP_JGZ, 8'h80, $urandom);
		run_instr(OP_JGE, 8'h10, $urandom);
		run_instr(OP_JLE, 8'h20, $urandom);
		run_instr(OP_STA, 8'h03, $urandom);
		run_instr(OP_OUT, 8'h03, $urandom);
		run_instr(OP_LDK, 8'h00, $urandom);
		run_instr(OP_JEZ, 8'hFF, $urandom);
		run_instr(OP_JNE, 8'h00, $urandom);
		run_instr(OP_DIV, 8'h00, $urandom);
		run_instr(OP_JMP, 8'h55, $urandom);
		run_instr(8'h00, 8'h12, $urandom);
		run_instr(8'hFF, 8'hED, $urandom);

		// Random well-formed stream with a quiet stretch and a few drains
		for (int i = 0; i < NUM_RANDOM; i++) begin
			steady = (i >= 500 && i < 800);
			if (i % 250 == 249)
				drain_results();
			random_instr(op, arg, inval);
			run_instr(op, arg, inval);
		end
		steady = 1'b0;

		// Stop the machine, by halt or by a zero divisor
		if ($urandom_range(1)) begin
			run_instr(OP_HLT, 8'($urandom_range(255)), $urandom);
		end else begin
			arg = 8'($urandom_range(255));
			run_instr(OP_INP, arg, 32'h0);
			run_instr(OP_DIV, arg, $urandom);
		end
		// Everything after the stop must be ignored
		for (int i = 0; i < 6; i++)
			run_instr(8'($urandom_range(255)), pick_stored(), $urandom);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (model.errors == 0 && model.pending_steps.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
